// ===== hw/rtl/bcfp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcfp_pkg
// Shared types, byte codes, status codes and the command name table.
// ----------------------------------------------------------------------------
package bcfp_pkg;

  localparam int TABLE_ROWS = 19;
  localparam int NAME_CHARS = 10;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [15:0] VALUE_LIMIT_RESET = 16'd100;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_OPEN  = 8'h7B;
  localparam logic [7:0] CH_CLOSE = 8'h7D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_OK_VAL = 2'd1;
  localparam logic [1:0] ST_ERR    = 2'd2;
  localparam logic [1:0] ST_OVF    = 2'd3;

  localparam logic [31:0] CMD_PFX = "CMD_";

  // Names are right-justified, zero filled on the left.
  localparam logic [NAME_CHARS*8-1:0] CMD_NAMES [TABLE_ROWS] = '{
    {8'h00, CMD_PFX, "START"}, {16'h0000, CMD_PFX, "STOP"}, {CMD_PFX, "STATUS"},
    {24'h000000, CMD_PFX, "S1T"}, {24'h000000, CMD_PFX, "S2T"},
    {24'h000000, CMD_PFX, "S3T"}, {16'h0000, CMD_PFX, "DETT"},
    {16'h0000, CMD_PFX, "H1S1"}, {16'h0000, CMD_PFX, "H2S1"},
    {16'h0000, CMD_PFX, "H3S1"}, {16'h0000, CMD_PFX, "H4S1"},
    {16'h0000, CMD_PFX, "H1S2"}, {16'h0000, CMD_PFX, "H2S2"},
    {16'h0000, CMD_PFX, "H3S2"}, {16'h0000, CMD_PFX, "H4S2"},
    {16'h0000, CMD_PFX, "H1S3"}, {16'h0000, CMD_PFX, "H2S3"},
    {16'h0000, CMD_PFX, "H3S3"}, {16'h0000, CMD_PFX, "H4S3"}
  };

  typedef enum logic [1:0] {
    TOK_BYTE,
    TOK_CLOSE,
    TOK_OVF
  } tok_kind_e;

  typedef struct packed {
    tok_kind_e   kind;
    logic [7:0]  data;
    logic        is_nul;
    logic        is_quote;
    logic        is_colon;
    logic        is_space;
    logic        is_digit;
    logic        is_sign;
    logic        is_minus;
  } token_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [4:0]  command_index;
    logic [15:0] command_value;
  } result_t;

  function automatic int cmd_len(int row);
    int n;
    n = 0;
    for (int k = 0; k < NAME_CHARS; k++) begin
      if (CMD_NAMES[row][k*8 +: 8] != CH_NUL) n++;
    end
    return n;
  endfunction

  function automatic logic [7:0] cmd_char(int row, int pos);
    logic [7:0] ch;
    int n;
    ch = CH_NUL;
    n = cmd_len(row);
    for (int k = 0; k < NAME_CHARS; k++) begin
      if (k < n && k == pos) ch = CMD_NAMES[row][(n-1-k)*8 +: 8];
    end
    return ch;
  endfunction

endpackage

// ===== hw/rtl/bcfp_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcfp_front
// Frame tracking and byte classification; emits tokens for in-frame bytes.
// ----------------------------------------------------------------------------
module bcfp_front import bcfp_pkg::*; #(
  parameter int MAX_FRAME_BYTES = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] rx_byte_i,
  output logic       push_o,
  output token_t     token_o
);

  localparam int LW = $clog2(MAX_FRAME_BYTES);
  localparam logic [LW-1:0] LEN_LIMIT = LW'(MAX_FRAME_BYTES - 2);

  logic          in_frame_q, in_frame_d;
  logic [LW-1:0] len_q, len_d;

  always_comb begin
    token_o.data     = rx_byte_i;
    token_o.is_nul   = (rx_byte_i == CH_NUL);
    token_o.is_quote = (rx_byte_i == CH_QUOTE);
    token_o.is_colon = (rx_byte_i == CH_COLON);
    token_o.is_space = (rx_byte_i == CH_SPACE) ||
                       (rx_byte_i >= CH_TAB && rx_byte_i <= CH_CR);
    token_o.is_digit = (rx_byte_i >= CH_ZERO && rx_byte_i <= CH_NINE);
    token_o.is_sign  = (rx_byte_i == CH_PLUS) || (rx_byte_i == CH_MINUS);
    token_o.is_minus = (rx_byte_i == CH_MINUS);
    token_o.kind     = TOK_BYTE;
    push_o           = 1'b0;
    in_frame_d       = in_frame_q;
    len_d            = len_q;
    if (accept_i) begin
      if (!in_frame_q) begin
        if (rx_byte_i == CH_OPEN) begin
          in_frame_d = 1'b1;
          len_d      = LW'(1);
        end
      end else if (len_q == LEN_LIMIT) begin
        push_o       = 1'b1;
        token_o.kind = TOK_OVF;
        in_frame_d   = 1'b0;
        len_d        = '0;
      end else begin
        push_o = 1'b1;
        len_d  = len_q + LW'(1);
        if (rx_byte_i == CH_CLOSE) begin
          token_o.kind = TOK_CLOSE;
          in_frame_d   = 1'b0;
          len_d        = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q <= 1'b0;
      len_q      <= '0;
    end else begin
      in_frame_q <= in_frame_d;
      len_q      <= len_d;
    end
  end

endmodule

// ===== hw/rtl/bcfp_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcfp_queue
// Short token queue between the front and the back.
// ----------------------------------------------------------------------------
module bcfp_queue import bcfp_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  token_t token_i,
  output logic   full_o,
  input  logic   pop_i,
  output logic   valid_o,
  output token_t token_o
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  token_t        mem_q [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CW-1:0] count_q, count_d;
  logic          do_push, do_pop;

  assign full_o  = (count_q == CW'(QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign token_o = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
    end
    if (do_push && !do_pop) count_d = count_q + CW'(1);
    else if (!do_push && do_pop) count_d = count_q - CW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= token_i;
  end

endmodule

// ===== hw/rtl/bcfp_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcfp_back
// Frame parser, incremental command prefix match and result register.
// ----------------------------------------------------------------------------
module bcfp_back import bcfp_pkg::*; #(
  parameter int KEY_MAX_CHARS = 10,
  parameter int COMMAND_COUNT = 19
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  input  token_t      token_i,
  output logic        pop_o,
  input  logic [15:0] value_limit_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output result_t     out_result_o
);

  localparam int ROWS = (COMMAND_COUNT < TABLE_ROWS) ? COMMAND_COUNT : TABLE_ROWS;
  localparam int KLW  = $clog2(KEY_MAX_CHARS + 1);

  localparam logic [2:0] PH_QUOTE = 3'd0;
  localparam logic [2:0] PH_KEY   = 3'd1;
  localparam logic [2:0] PH_COLON = 3'd2;
  localparam logic [2:0] PH_WS    = 3'd3;
  localparam logic [2:0] PH_SIGN  = 3'd4;
  localparam logic [2:0] PH_DIGIT = 3'd5;
  localparam logic [2:0] PH_STOP  = 3'd6;

  logic [2:0]      phase_q, phase_d, phase_n;
  logic [KLW-1:0]  key_len_q, key_len_d, key_len_n;
  logic [ROWS-1:0] alive_q, alive_d, alive_n, char_ok, hit;
  logic [16:0]     acc_q, acc_d, acc_n;
  logic            neg_q, neg_d, neg_n;
  logic            ovf_q, ovf_d, ovf_n;
  logic            digits_q, digits_d, digits_n;
  logic [20:0]     acc_x10;
  logic            need_out, out_free, found, val_ok;
  logic [4:0]      idx;
  logic            out_valid_q, out_valid_d;
  result_t         out_result_q, out_result_d;

  assign need_out    = (token_i.kind != TOK_BYTE);
  assign out_free    = !out_valid_q || out_ready_i;
  assign pop_o       = valid_i && (!need_out || out_free);
  assign out_valid_o = out_valid_q;
  assign out_result_o = out_result_q;

  assign acc_x10 = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0} +
                   {17'd0, token_i.data[3:0] - CH_ZERO[3:0]};

  always_comb begin
    for (int i = 0; i < ROWS; i++) begin
      char_ok[i] = (key_len_q >= KLW'(cmd_len(i))) ||
                   (token_i.data == cmd_char(i, int'(key_len_q)));
    end
  end

  // parse one byte
  always_comb begin
    phase_n   = phase_q;
    key_len_n = key_len_q;
    alive_n   = alive_q;
    acc_n     = acc_q;
    neg_n     = neg_q;
    ovf_n     = ovf_q;
    digits_n  = digits_q;
    if (token_i.is_nul) begin
      phase_n = PH_STOP;
    end else begin
      case (phase_q)
        PH_QUOTE: begin
          phase_n = token_i.is_quote ? PH_KEY : PH_STOP;
        end
        PH_KEY: begin
          if (token_i.is_quote) begin
            phase_n = (key_len_q != '0) ? PH_COLON : PH_STOP;
          end else if (key_len_q < KLW'(KEY_MAX_CHARS)) begin
            key_len_n = key_len_q + KLW'(1);
            alive_n   = alive_q & char_ok;
          end else begin
            phase_n = PH_STOP;
          end
        end
        PH_COLON: begin
          phase_n = token_i.is_colon ? PH_WS : PH_STOP;
        end
        PH_WS, PH_SIGN, PH_DIGIT: begin
          if (phase_q == PH_WS && token_i.is_space) begin
            phase_n = PH_WS;
          end else if (phase_q == PH_WS && token_i.is_sign) begin
            neg_n   = token_i.is_minus;
            phase_n = PH_SIGN;
          end else if (token_i.is_digit) begin
            digits_n = 1'b1;
            phase_n  = PH_DIGIT;
            if (!ovf_q) begin
              acc_n = acc_x10[16:0];
              ovf_n = (acc_x10[20:17] != 4'd0);
            end
          end else begin
            phase_n = PH_STOP;
          end
        end
        default: begin
          phase_n = PH_STOP;
        end
      endcase
    end
  end

  always_comb begin
    hit   = alive_n;
    found = 1'b0;
    idx   = 5'd0;
    for (int i = 0; i < ROWS; i++) begin
      hit[i] = alive_n[i] && (key_len_n >= KLW'(cmd_len(i)));
    end
    for (int i = ROWS - 1; i >= 0; i--) begin
      if (hit[i]) begin
        found = 1'b1;
        idx   = 5'(i);
      end
    end
    if (key_len_n == '0) found = 1'b0;
    val_ok = !ovf_q && (acc_q == 17'd0 || !neg_q) && (acc_q <= {1'b0, value_limit_i});
  end

  always_comb begin
    phase_d      = phase_q;
    key_len_d    = key_len_q;
    alive_d      = alive_q;
    acc_d        = acc_q;
    neg_d        = neg_q;
    ovf_d        = ovf_q;
    digits_d     = digits_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_result_d = out_result_q;
    if (pop_o) begin
      if (need_out) begin
        phase_d     = PH_QUOTE;
        key_len_d   = '0;
        alive_d     = '1;
        acc_d       = '0;
        neg_d       = 1'b0;
        ovf_d       = 1'b0;
        digits_d    = 1'b0;
        out_valid_d = 1'b1;
        out_result_d.status        = ST_ERR;
        out_result_d.command_index = 5'd0;
        out_result_d.command_value = 16'd0;
        if (token_i.kind == TOK_OVF) begin
          out_result_d.status = ST_OVF;
        end else if (found) begin
          out_result_d.command_index = idx;
          if (!digits_q) begin
            out_result_d.status = ST_OK;
          end else if (val_ok) begin
            out_result_d.status        = ST_OK_VAL;
            out_result_d.command_value = acc_q[15:0];
          end
        end
      end else begin
        phase_d   = phase_n;
        key_len_d = key_len_n;
        alive_d   = alive_n;
        acc_d     = acc_n;
        neg_d     = neg_n;
        ovf_d     = ovf_n;
        digits_d  = digits_n;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_QUOTE;
      key_len_q   <= '0;
      alive_q     <= '1;
      acc_q       <= '0;
      neg_q       <= 1'b0;
      ovf_q       <= 1'b0;
      digits_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      key_len_q   <= key_len_d;
      alive_q     <= alive_d;
      acc_q       <= acc_d;
      neg_q       <= neg_d;
      ovf_q       <= ovf_d;
      digits_q    <= digits_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_result_q <= out_result_d;
  end

endmodule

// ===== hw/rtl/brace_command_frame_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brace_command_frame_parser
// Parses {"KEY":value} command frames from a byte stream, one result a frame.
// Throughput: one byte per cycle; a result held on m_axis backs up the input.
// A closing or overflowing byte is first written into the token queue; its result
// is registered on m_axis when the back pops it and m_axis is free.
// Reset: async active low; leaves frame and parser idle, value_limit = 100.
// ----------------------------------------------------------------------------
module brace_command_frame_parser import bcfp_pkg::*; #(
  parameter int MAX_FRAME_BYTES = 64,
  parameter int KEY_MAX_CHARS   = 10,
  parameter int COMMAND_COUNT   = 19
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [1:0] status, [6:2] command_index,
                                      // [22:7] command_value, [23] zero
  input  logic        cfg_wr_en_i,
  input  logic [15:0] cfg_wr_data_i
);

  logic        q_full, push, q_valid, pop, accept;
  token_t      front_tok, back_tok;
  result_t     result;
  logic [15:0] value_limit_q;

  assign s_axis_tready = !q_full;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tdata  = {1'b0, result.command_value, result.command_index,
                          result.status};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      value_limit_q <= VALUE_LIMIT_RESET;
    end else if (cfg_wr_en_i) begin
      value_limit_q <= cfg_wr_data_i;
    end
  end

  bcfp_front #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .rx_byte_i(s_axis_tdata),
    .push_o   (push),
    .token_o  (front_tok)
  );

  bcfp_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .token_i(front_tok),
    .full_o (q_full),
    .pop_i  (pop),
    .valid_o(q_valid),
    .token_o(back_tok)
  );

  bcfp_back #(
    .KEY_MAX_CHARS(KEY_MAX_CHARS),
    .COMMAND_COUNT(COMMAND_COUNT)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (q_valid),
    .token_i      (back_tok),
    .pop_o        (pop),
    .value_limit_i(value_limit_q),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_result_o (result)
  );

endmodule
